// ----- rtl/cpsat_pkg.sv -----
package cpsat_pkg;

   localparam int MaxVertices = 16;
   localparam int MaxNormals  = 16;
   localparam int VIdxW = $clog2(MaxVertices);
   localparam int NIdxW = $clog2(MaxNormals);
   localparam int VCntW = $clog2(MaxVertices + 1);
   localparam int NCntW = $clog2(MaxNormals + 1);

   localparam int CoordW = 24;
   localparam int AxisW  = 16;
   localparam int DepthW = 42;
   localparam int ProdW  = CoordW + AxisW;
   localparam int ProjW  = ProdW + 1;
   localparam int MtvW   = ProjW + 2;

   localparam logic [DepthW-1:0] DepthMax = '1;

   typedef enum logic [1:0] {
      OP_VERT_A = 2'd0,
      OP_VERT_B = 2'd1,
      OP_AXIS_A = 2'd2,
      OP_AXIS_B = 2'd3
   } op_type;

   typedef struct packed {
      op_type            operation;
      logic [CoordW-1:0] vertex_x;
      logic [CoordW-1:0] vertex_y;
      logic [AxisW-1:0]  axis_x;
      logic [AxisW-1:0]  axis_y;
      logic              last;
   } req_type;

   typedef struct packed {
      logic              collides;
      logic [AxisW-1:0]  best_normal_x;
      logic [AxisW-1:0]  best_normal_y;
      logic [DepthW-1:0] depth;
      logic              overflow;
   } rsp_type;

   // Command passed from the loader to the test engine through the queue.
   typedef struct packed {
      logic [VCntW-1:0] n_verts_a;
      logic [VCntW-1:0] n_verts_b;
      logic [NCntW-1:0] n_axes_a;
      logic [NCntW-1:0] n_axes_b;
      logic             overflow;
   } job_type;

   function automatic logic signed [AxisW-1:0] neg16(input logic signed [AxisW-1:0] v);
      neg16 = (v == {1'b1, {(AxisW-1){1'b0}}}) ? {1'b0, {(AxisW-1){1'b1}}} : -v;
   endfunction

endpackage

// ----- rtl/cpsat_if.sv -----
interface cpsat_req_if;
   import cpsat_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface cpsat_rsp_if;
   import cpsat_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/cpsat_ram.sv -----
module cpsat_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/cpsat_loader.sv -----
module cpsat_loader (
   input  logic                      clock,
   input  logic                      reset,
   cpsat_req_if.sink                 req,
   input  logic                      job_ready,
   output logic                      job_valid,
   output cpsat_pkg::job_type        job,
   output logic                      wr_va,
   output logic                      wr_vb,
   output logic                      wr_na,
   output logic                      wr_nb,
   output logic [cpsat_pkg::VIdxW-1:0] wr_vaddr,
   output logic [cpsat_pkg::NIdxW-1:0] wr_naddr
);
   import cpsat_pkg::*;

   logic [VCntW-1:0] cnt_va_ff, cnt_va_in, cnt_vb_ff, cnt_vb_in;
   logic [NCntW-1:0] cnt_na_ff, cnt_na_in, cnt_nb_ff, cnt_nb_in;
   logic             drop_ff, drop_in;
   logic             fire, full;

   // Hold every load item while a job is queued or running: the stores are
   // shared with the engine.
   assign req.ready = job_ready;
   assign fire      = req.valid && req.ready;

   always_comb begin
      cnt_va_in = cnt_va_ff;
      cnt_vb_in = cnt_vb_ff;
      cnt_na_in = cnt_na_ff;
      cnt_nb_in = cnt_nb_ff;
      full      = 1'b0;
      wr_va = 1'b0; wr_vb = 1'b0; wr_na = 1'b0; wr_nb = 1'b0;
      wr_vaddr = '0;
      wr_naddr = '0;
      unique case (req.data.operation)
         OP_VERT_A: begin
            full = (cnt_va_ff == VCntW'(MaxVertices));
            wr_vaddr = cnt_va_ff[VIdxW-1:0];
            wr_va = fire && !full;
            if (wr_va) cnt_va_in = cnt_va_ff + 1'b1;
         end
         OP_VERT_B: begin
            full = (cnt_vb_ff == VCntW'(MaxVertices));
            wr_vaddr = cnt_vb_ff[VIdxW-1:0];
            wr_vb = fire && !full;
            if (wr_vb) cnt_vb_in = cnt_vb_ff + 1'b1;
         end
         OP_AXIS_A: begin
            full = (cnt_na_ff == NCntW'(MaxNormals));
            wr_naddr = cnt_na_ff[NIdxW-1:0];
            wr_na = fire && !full;
            if (wr_na) cnt_na_in = cnt_na_ff + 1'b1;
         end
         OP_AXIS_B: begin
            full = (cnt_nb_ff == NCntW'(MaxNormals));
            wr_naddr = cnt_nb_ff[NIdxW-1:0];
            wr_nb = fire && !full;
            if (wr_nb) cnt_nb_in = cnt_nb_ff + 1'b1;
         end
         default: ;
      endcase
      drop_in = drop_ff || (fire && full);
      job.n_verts_a = cnt_va_in;
      job.n_verts_b = cnt_vb_in;
      job.n_axes_a  = cnt_na_in;
      job.n_axes_b  = cnt_nb_in;
      job.overflow  = drop_in;
      job_valid     = fire && req.data.last;
      if (job_valid) begin
         cnt_va_in = '0; cnt_vb_in = '0; cnt_na_in = '0; cnt_nb_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_va_ff <= '0; cnt_vb_ff <= '0; cnt_na_ff <= '0; cnt_nb_ff <= '0;
         drop_ff   <= 1'b0;
      end else begin
         cnt_va_ff <= cnt_va_in; cnt_vb_ff <= cnt_vb_in;
         cnt_na_ff <= cnt_na_in; cnt_nb_ff <= cnt_nb_in;
         drop_ff   <= drop_in;
      end
   end
endmodule

// ----- rtl/cpsat_engine.sv -----
module cpsat_engine (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        job_valid,
   output logic                        job_ready,
   input  cpsat_pkg::job_type          job,
   output logic [cpsat_pkg::VIdxW-1:0] rd_vaddr,
   output logic [cpsat_pkg::NIdxW-1:0] rd_naddr,
   output logic                        rd_set_b,
   input  logic [2*cpsat_pkg::CoordW-1:0] va_data,
   input  logic [2*cpsat_pkg::CoordW-1:0] vb_data,
   input  logic [2*cpsat_pkg::AxisW-1:0]  na_data,
   input  logic [2*cpsat_pkg::AxisW-1:0]  nb_data,
   cpsat_rsp_if.source                 rsp
);
   import cpsat_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_AXIS_RD, S_AXIS_LD, S_WALK, S_DRAIN, S_EVAL, S_DONE
   } state_type;

   state_type               state_ff;
   job_type                 job_ff;
   logic                    pass_ff;
   logic [NCntW-1:0]        k_ff;
   logic [VCntW-1:0]        i_ff;
   logic [1:0]              pipe_ff;        // valid bits: read, product
   logic [1:0]              pipe_b_ff;      // which set each stage holds
   logic signed [AxisW-1:0] ax_ff, ay_ff;
   logic signed [ProdW-1:0] px_ff, py_ff;
   logic signed [ProjW-1:0] mina_ff, maxa_ff, minb_ff, maxb_ff;
   logic                    have_a_ff, have_b_ff;
   logic                    have_ff, coll_ff;
   logic signed [MtvW-1:0]  best_ff;
   logic signed [AxisW-1:0] bx_ff, by_ff;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_ff;

   logic [VCntW-1:0]        n_cur;
   logic [NCntW-1:0]        n_axes;
   logic [2*CoordW-1:0]     vdat;
   logic signed [ProjW-1:0] proj;
   logic signed [ProjW-1:0] lo_max, hi_min;
   logic signed [MtvW-1:0]  mtv, glo, ghi;
   logic                    contain, negate;
   logic signed [AxisW-1:0] cx, cy;

   assign job_ready = (state_ff == S_IDLE);
   assign n_axes    = pass_ff ? job_ff.n_axes_b : job_ff.n_axes_a;
   assign n_cur     = rd_set_b ? job_ff.n_verts_b : job_ff.n_verts_a;
   assign vdat      = pipe_b_ff[0] ? vb_data : va_data;
   assign proj      = ProjW'(px_ff) + ProjW'(py_ff);
   assign rd_naddr  = k_ff[NIdxW-1:0];
   assign rd_vaddr  = i_ff[VIdxW-1:0];
   // Set being walked: A indices first, then B.
   assign rd_set_b  = pipe_b_ff[0];

   assign lo_max  = (mina_ff > minb_ff) ? mina_ff : minb_ff;
   assign hi_min  = (maxa_ff < maxb_ff) ? maxa_ff : maxb_ff;
   assign glo     = (mina_ff > minb_ff) ? MtvW'(mina_ff) - MtvW'(minb_ff)
                                        : MtvW'(minb_ff) - MtvW'(mina_ff);
   assign ghi     = (maxa_ff > maxb_ff) ? MtvW'(maxa_ff) - MtvW'(maxb_ff)
                                        : MtvW'(maxb_ff) - MtvW'(maxa_ff);
   assign contain = (mina_ff > minb_ff && maxa_ff < maxb_ff) ||
                    (minb_ff > mina_ff && maxb_ff < maxa_ff);
   assign negate  = contain && (glo < ghi);
   assign mtv     = MtvW'(hi_min) - MtvW'(lo_max) + (contain ? (negate ? glo : ghi) : '0);
   assign cx      = negate ? neg16(ax_ff) : ax_ff;
   assign cy      = negate ? neg16(ay_ff) : ay_ff;

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         pipe_ff      <= '0;
      end else begin
         if (rsp_valid_ff && rsp.ready && state_ff != S_DONE) rsp_valid_ff <= 1'b0;
         // Dot product pipeline: read data -> two products -> sum and min/max.
         pipe_ff[0] <= (state_ff == S_WALK) && (i_ff != n_cur);
         pipe_ff[1] <= pipe_ff[0];
         pipe_b_ff[1] <= pipe_b_ff[0];
         px_ff <= ProdW'(ax_ff * $signed(vdat[2*CoordW-1:CoordW]));
         py_ff <= ProdW'(ay_ff * $signed(vdat[CoordW-1:0]));
         if (pipe_ff[1]) begin
            if (!pipe_b_ff[1]) begin
               if (!have_a_ff || proj < mina_ff) mina_ff <= proj;
               if (!have_a_ff || proj > maxa_ff) maxa_ff <= proj;
               have_a_ff <= 1'b1;
            end else begin
               if (!have_b_ff || proj < minb_ff) minb_ff <= proj;
               if (!have_b_ff || proj > maxb_ff) maxb_ff <= proj;
               have_b_ff <= 1'b1;
            end
         end
         unique case (state_ff)
            S_IDLE: if (job_valid) begin
               job_ff <= job; pass_ff <= 1'b0; k_ff <= '0;
               have_ff <= 1'b0; coll_ff <= 1'b1;
               bx_ff <= '0; by_ff <= '0; best_ff <= '0;
               state_ff <= S_AXIS_RD;
            end
            S_AXIS_RD: begin
               if (k_ff == n_axes) begin
                  if (!pass_ff) begin
                     pass_ff <= 1'b1; k_ff <= '0;
                  end else state_ff <= S_DONE;
               end else state_ff <= S_AXIS_LD;
            end
            S_AXIS_LD: begin
               ax_ff <= $signed(pass_ff ? nb_data[2*AxisW-1:AxisW] : na_data[2*AxisW-1:AxisW]);
               ay_ff <= $signed(pass_ff ? nb_data[AxisW-1:0] : na_data[AxisW-1:0]);
               i_ff <= '0; pipe_b_ff[0] <= 1'b0;
               have_a_ff <= 1'b0; have_b_ff <= 1'b0;
               state_ff <= S_WALK;
            end
            S_WALK: begin
               // Issue one read per cycle: A indices, then B indices.
               if (i_ff == n_cur) begin
                  if (!pipe_b_ff[0]) begin
                     pipe_b_ff[0] <= 1'b1; i_ff <= '0;
                  end else state_ff <= S_DRAIN;
               end else begin
                  i_ff <= i_ff + 1'b1;
               end
            end
            S_DRAIN: if (!pipe_ff[0] && !pipe_ff[1]) state_ff <= S_EVAL;
            S_EVAL: begin
               if (!have_a_ff || !have_b_ff || mina_ff > maxb_ff || minb_ff > maxa_ff) begin
                  coll_ff <= 1'b0; state_ff <= S_DONE;
               end else begin
                  if (!have_ff || mtv < best_ff) begin
                     have_ff <= 1'b1; best_ff <= mtv; bx_ff <= cx; by_ff <= cy;
                  end
                  k_ff <= k_ff + 1'b1;
                  state_ff <= S_AXIS_RD;
               end
            end
            S_DONE: if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_ff <= 1'b1;
               rsp_ff.collides      <= coll_ff;
               rsp_ff.best_normal_x <= coll_ff ? bx_ff : '0;
               rsp_ff.best_normal_y <= coll_ff ? by_ff : '0;
               rsp_ff.overflow      <= job_ff.overflow;
               if (!coll_ff) rsp_ff.depth <= '0;
               else if (!have_ff || best_ff > $signed(MtvW'(DepthMax)))
                  rsp_ff.depth <= DepthMax;
               else rsp_ff.depth <= DepthW'(best_ff);
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ----- rtl/convex_polygon_sat_collision_top.sv -----
// Channel | Dir | Payload                                      | Handshake
// req_    | in  | operation, vertex x/y, axis x/y, last        | req_valid / req_ready
// rsp_    | out | collides, best normal x/y, depth, overflow   | rsp_valid / rsp_ready
// Load items take one cycle each while the job queue is empty and the engine is
// idle. After a last item the engine walks each axis over both vertex sets,
// stopping early when an axis separates; the single multiplier pair walks the
// vertex memories one entry per cycle. Reset is synchronous and clears counts
// and flags only. Every load item stalls while a job is queued or running.
module convex_polygon_sat_collision_top (
   input logic  clock,
   input logic  reset,
   cpsat_req_if.sink   req,
   cpsat_rsp_if.source rsp
);
   import cpsat_pkg::*;

   logic              job_valid, job_ready, eng_ready;
   job_type           job_in, job_q;
   logic              q_valid_ff;
   job_type           q_data_ff;
   logic              wr_va, wr_vb, wr_na, wr_nb, rd_set_b;
   logic [VIdxW-1:0]  wr_vaddr, rd_vaddr;
   logic [NIdxW-1:0]  wr_naddr, rd_naddr;
   logic [2*CoordW-1:0] va_data, vb_data;
   logic [2*AxisW-1:0]  na_data, nb_data;

   // Loader: store vectors, count them, and hand a job to the engine.
   cpsat_loader u_loader (
      .clock, .reset, .req,
      .job_ready, .job_valid, .job(job_in),
      .wr_va, .wr_vb, .wr_na, .wr_nb, .wr_vaddr, .wr_naddr
   );

   // One-entry job queue; accept a new job only when empty and the engine is
   // idle, since the stores are shared with the next load.
   assign job_ready = !q_valid_ff && eng_ready;
   assign job_q     = q_data_ff;
   always_ff @(posedge clock) begin
      if (reset) q_valid_ff <= 1'b0;
      else if (job_valid) q_valid_ff <= 1'b1;
      else if (q_valid_ff && eng_ready) q_valid_ff <= 1'b0;
      if (job_valid) q_data_ff <= job_in;
   end

   cpsat_ram #(.Width(2*CoordW), .Depth(MaxVertices)) u_va (
      .clock, .wr_en(wr_va), .wr_addr(wr_vaddr),
      .wr_data({req.data.vertex_x, req.data.vertex_y}),
      .rd_addr(rd_vaddr), .rd_data(va_data));
   cpsat_ram #(.Width(2*CoordW), .Depth(MaxVertices)) u_vb (
      .clock, .wr_en(wr_vb), .wr_addr(wr_vaddr),
      .wr_data({req.data.vertex_x, req.data.vertex_y}),
      .rd_addr(rd_vaddr), .rd_data(vb_data));
   cpsat_ram #(.Width(2*AxisW), .Depth(MaxNormals)) u_na (
      .clock, .wr_en(wr_na), .wr_addr(wr_naddr),
      .wr_data({req.data.axis_x, req.data.axis_y}),
      .rd_addr(rd_naddr), .rd_data(na_data));
   cpsat_ram #(.Width(2*AxisW), .Depth(MaxNormals)) u_nb (
      .clock, .wr_en(wr_nb), .wr_addr(wr_naddr),
      .wr_data({req.data.axis_x, req.data.axis_y}),
      .rd_addr(rd_naddr), .rd_data(nb_data));

   // Engine: walk each axis over both vertex sets and track the best.
   cpsat_engine u_engine (
      .clock, .reset,
      .job_valid(q_valid_ff), .job_ready(eng_ready), .job(job_q),
      .rd_vaddr, .rd_naddr, .rd_set_b,
      .va_data, .vb_data, .na_data, .nb_data, .rsp
   );

   logic unused_set_b;
   assign unused_set_b = rd_set_b;
endmodule

// ----- dv/tb_convex_polygon_sat_collision_top.sv -----
`timescale 1ns / 1ps

module tb_convex_polygon_sat_collision_top;
   import cpsat_pkg::*;

   localparam int      RandItems  = 1825;
   localparam int      IdleLimit  = 20000;
   localparam longint  DepthTop   = (longint'(1) << DepthW) - 1;

   logic clock;
   logic reset;

   cpsat_req_if req_ch ();
   cpsat_rsp_if rsp_ch ();

   convex_polygon_sat_collision_top u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // Directed stimulus rows. A row with has_exp carries a hand-typed result;
   // other last rows take their result from the collision predictor.
   typedef struct {
      req_type item;
      bit      has_exp;
      rsp_type exp;
   } row_type;

   row_type   plan[$];
   rsp_type   expected_hits[$];
   int        n_sent;
   int        n_errors;
   int        idle_cycles;
   bit        long_hold_done;
   bit        no_gaps;

   // Shadow copy of the polygon stores.
   longint    sv_ax[MaxVertices], sv_ay[MaxVertices];
   longint    sv_bx[MaxVertices], sv_by[MaxVertices];
   longint    sn_ax[MaxNormals],  sn_ay[MaxNormals];
   longint    sn_bx[MaxNormals],  sn_by[MaxNormals];
   int        cnt_va, cnt_vb, cnt_na, cnt_nb;
   bit        sticky_drop;

   always #5 clock = ~clock;

   // Saturating negate of a Q1.14 component.
   function automatic longint flip_axis(input longint v);
      if (v <= -32768) return 32767;
      return -v;
   endfunction

   // Project a vertex set onto an axis; returns 0 on an empty set.
   function automatic bit span_of(input bit poly_b, input longint nx, input longint ny,
                                  output longint lo, output longint hi);
      longint d;
      int     n;
      n  = poly_b ? cnt_vb : cnt_va;
      lo = 0;
      hi = 0;
      for (int i = 0; i < n; i++) begin
         d = poly_b ? nx * sv_bx[i] + ny * sv_by[i] : nx * sv_ax[i] + ny * sv_ay[i];
         if (i == 0 || d < lo) lo = d;
         if (i == 0 || d > hi) hi = d;
      end
      return n != 0;
   endfunction

   // Store one transaction into the shadow state; on last, compute the
   // collision result and clear the counts.
   function automatic bit collide_predict(input req_type r, output rsp_type o);
      longint vx, vy, nx, ny, mina, maxa, minb, maxb, mtv, glo, ghi, best_d;
      longint bx, by;
      bit     hit, have, oka, okb;
      int     n;
      vx = longint'($signed(r.vertex_x));
      vy = longint'($signed(r.vertex_y));
      nx = longint'($signed(r.axis_x));
      ny = longint'($signed(r.axis_y));
      case (r.operation)
         OP_VERT_A: if (cnt_va < MaxVertices) begin
               sv_ax[cnt_va] = vx; sv_ay[cnt_va] = vy; cnt_va++;
            end else sticky_drop = 1;
         OP_VERT_B: if (cnt_vb < MaxVertices) begin
               sv_bx[cnt_vb] = vx; sv_by[cnt_vb] = vy; cnt_vb++;
            end else sticky_drop = 1;
         OP_AXIS_A: if (cnt_na < MaxNormals) begin
               sn_ax[cnt_na] = nx; sn_ay[cnt_na] = ny; cnt_na++;
            end else sticky_drop = 1;
         default: if (cnt_nb < MaxNormals) begin
               sn_bx[cnt_nb] = nx; sn_by[cnt_nb] = ny; cnt_nb++;
            end else sticky_drop = 1;
      endcase
      o = '0;
      if (!r.last) return 0;

      hit    = 1;
      have   = 0;
      best_d = 0;
      bx     = 0;
      by     = 0;
      for (int pass = 0; pass < 2 && hit; pass++) begin
         n = pass == 0 ? cnt_na : cnt_nb;
         for (int k = 0; k < n; k++) begin
            nx  = pass == 0 ? sn_ax[k] : sn_bx[k];
            ny  = pass == 0 ? sn_ay[k] : sn_by[k];
            oka = span_of(0, nx, ny, mina, maxa);
            okb = span_of(1, nx, ny, minb, maxb);
            // stop at the first separating axis
            if (!oka || !okb || mina > maxb || minb > maxa) begin
               hit = 0;
               break;
            end
            mtv = (maxa < maxb ? maxa : maxb) - (mina > minb ? mina : minb);
            if ((mina > minb && maxa < maxb) || (minb > mina && maxb < maxa)) begin
               glo = mina > minb ? mina - minb : minb - mina;
               ghi = maxa > maxb ? maxa - maxb : maxb - maxa;
               if (glo < ghi) begin
                  mtv += glo;
                  nx = flip_axis(nx);
                  ny = flip_axis(ny);
               end else begin
                  mtv += ghi;
               end
            end
            if (!have || mtv < best_d) begin
               have   = 1;
               bx     = nx;
               by     = ny;
               best_d = mtv;
            end
         end
      end

      o.collides = hit;
      o.overflow = sticky_drop;
      if (!hit) begin
         o.depth = '0;
      end else if (!have) begin
         o.depth = DepthMax;
      end else begin
         o.best_normal_x = bx[AxisW-1:0];
         o.best_normal_y = by[AxisW-1:0];
         o.depth = best_d > DepthTop ? DepthMax : best_d[DepthW-1:0];
      end
      cnt_va = 0;
      cnt_vb = 0;
      cnt_na = 0;
      cnt_nb = 0;
      return 1;
   endfunction

   // Build a transaction; the unused fields carry random filler.
   function automatic req_type mk(input op_type op, input int x, input int y,
                                  input int ax, input int ay, input bit last);
      req_type r;
      r.operation = op;
      r.last      = last;
      if (op == OP_VERT_A || op == OP_VERT_B) begin
         r.vertex_x = x[CoordW-1:0];
         r.vertex_y = y[CoordW-1:0];
         r.axis_x   = $urandom;
         r.axis_y   = $urandom;
      end else begin
         r.vertex_x = $urandom;
         r.vertex_y = $urandom;
         r.axis_x   = ax[AxisW-1:0];
         r.axis_y   = ay[AxisW-1:0];
      end
      return r;
   endfunction

   function automatic rsp_type typed_rsp(input bit c, input logic [DepthW-1:0] d,
                                         input bit ov);
      rsp_type o;
      o          = '0;
      o.collides = c;
      o.depth    = d;
      o.overflow = ov;
      return o;
   endfunction

   task automatic plan_row(input req_type r, input bit has_exp, input rsp_type e);
      row_type w;
      w.item    = r;
      w.has_exp = has_exp;
      w.exp     = e;
      plan.push_back(w);
   endtask

   // Hold a gap, then offer one transaction until it is accepted.
   task automatic send_item(input req_type r, input bit has_exp, input rsp_type e);
      int      roll, gap;
      rsp_type p;
      roll = $urandom_range(0, 99);
      gap  = no_gaps || roll < 45 ? 0 : roll < 92 ? $urandom_range(1, 3)
                                              : $urandom_range(10, 40);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= r;
      do @(posedge clock); while (!req_ch.ready);
      n_sent++;
      if (collide_predict(r, p)) expected_hits.push_back(has_exp ? e : p);
      @(negedge clock);
   endtask

   function automatic int spread(input int span);
      return $urandom_range(0, 2 * span) - span;
   endfunction

   // One polygon pair: mostly well-formed loads with random content, some
   // shuffled order, and late in the run an occasional overfilled store.
   task automatic send_pair(input bit allow_spill);
      req_type  q[$];
      req_type  t;
      rsp_type  none;
      int       mode, span, cx, cy, ox, oy, nva, nvb, nna, nnb, j, alim;
      mode  = $urandom_range(0, 9);
      span  = mode == 0 ? 4000000 : mode < 3 ? 200000 : 3000;
      alim  = $urandom_range(0, 3) == 0 ? 32767 : 16384;
      cx    = spread(mode == 0 ? 0 : 4000000);
      cy    = spread(mode == 0 ? 0 : 4000000);
      ox    = spread(span);
      oy    = spread(span);
      nva   = $urandom_range(0, 19) == 0 ? 0 : $urandom_range(1, 6);
      nvb   = $urandom_range(0, 19) == 0 ? 0 : $urandom_range(1, 6);
      nna   = $urandom_range(0, 4);
      nnb   = $urandom_range(0, 4);
      if (allow_spill && $urandom_range(0, 29) == 0) begin
         case ($urandom_range(0, 3))
            0: nva = $urandom_range(17, 19);
            1: nvb = $urandom_range(17, 19);
            2: nna = $urandom_range(17, 19);
            default: nnb = $urandom_range(17, 19);
         endcase
      end
      none = '0;
      for (int i = 0; i < nva; i++)
         q.push_back(mk(OP_VERT_A, cx + spread(span), cy + spread(span), 0, 0, 0));
      for (int i = 0; i < nvb; i++)
         q.push_back(mk(OP_VERT_B, cx + ox + spread(span), cy + oy + spread(span), 0, 0, 0));
      for (int i = 0; i < nna; i++)
         q.push_back(mk(OP_AXIS_A, 0, 0, spread(alim), spread(alim), 0));
      for (int i = 0; i < nnb; i++)
         q.push_back(mk(OP_AXIS_B, 0, 0, spread(alim), spread(alim), 0));
      if (q.size() == 0) q.push_back(mk(OP_VERT_A, cx, cy, 0, 0, 0));
      // scramble the load order now and then
      if ($urandom_range(0, 9) == 0) begin
         for (int i = q.size() - 1; i > 0; i--) begin
            j    = $urandom_range(0, i);
            t    = q[i];
            q[i] = q[j];
            q[j] = t;
         end
      end
      q[q.size()-1].last = 1'b1;
      foreach (q[i]) send_item(q[i], 0, none);
   endtask

   task automatic build_plan();
      rsp_type none;
      none = '0;
      // no axes at all: collision with maximum depth
      plan_row(mk(OP_VERT_A, 0, 0, 0, 0, 1), 1, typed_rsp(1, DepthMax, 0));
      // axis with no vertices: separated at once
      plan_row(mk(OP_AXIS_A, 0, 0, 16384, 0, 1), 1, typed_rsp(0, '0, 0));
      // coordinate and axis extremes
      plan_row(mk(OP_VERT_A, 8388607, 8388607, 0, 0, 0), 0, none);
      plan_row(mk(OP_VERT_A, -8388608, -8388608, 0, 0, 0), 0, none);
      plan_row(mk(OP_VERT_B, 0, 0, 0, 0, 0), 0, none);
      plan_row(mk(OP_VERT_B, 100, -5, 0, 0, 0), 0, none);
      plan_row(mk(OP_AXIS_A, 0, 0, 32767, 32767, 0), 0, none);
      plan_row(mk(OP_AXIS_B, 0, 0, -32767, 0, 1), 0, none);
      // containment with the low-end gap smaller, on an axis that saturates
      plan_row(mk(OP_VERT_A, 90, 0, 0, 0, 0), 0, none);
      plan_row(mk(OP_VERT_A, 95, 0, 0, 0, 0), 0, none);
      plan_row(mk(OP_VERT_B, 0, 0, 0, 0, 0), 0, none);
      plan_row(mk(OP_VERT_B, 100, 0, 0, 0, 0), 0, none);
      plan_row(mk(OP_AXIS_A, 0, 0, -32768, -32768, 1), 0, none);
      // equal overlaps on two axes: the first one holds
      plan_row(mk(OP_VERT_A, 0, 0, 0, 0, 0), 0, none);
      plan_row(mk(OP_VERT_A, 256, 0, 0, 0, 0), 0, none);
      plan_row(mk(OP_VERT_B, 128, 0, 0, 0, 0), 0, none);
      plan_row(mk(OP_VERT_B, 384, 0, 0, 0, 0), 0, none);
      plan_row(mk(OP_AXIS_A, 0, 0, 16384, 0, 0), 0, none);
      plan_row(mk(OP_AXIS_B, 0, 0, 16384, 0, 0), 0, none);
      plan_row(mk(OP_AXIS_B, 0, 0, -16384, 0, 1), 0, none);
      // separated on the second polygon's axis
      plan_row(mk(OP_VERT_A, 0, 0, 0, 0, 0), 0, none);
      plan_row(mk(OP_VERT_B, 0, 5000, 0, 0, 0), 0, none);
      plan_row(mk(OP_AXIS_A, 0, 0, 16384, 0, 0), 0, none);
      plan_row(mk(OP_AXIS_B, 0, 0, 0, 16384, 1), 0, none);
   endtask

   // Stimulus: reset, the directed table, then random polygon pairs.
   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.data    = '0;
      n_sent         = 0;
      n_errors       = 0;
      no_gaps        = 0;
      cnt_va         = 0;
      cnt_vb         = 0;
      cnt_na         = 0;
      cnt_nb         = 0;
      sticky_drop    = 0;
      build_plan();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      foreach (plan[i]) send_item(plan[i].item, plan[i].has_exp, plan[i].exp);
      while (n_sent < RandItems + plan.size()) begin
         // alternate stretches with and without sender gaps
         no_gaps = ((n_sent / 150) % 4) == 3;
         send_pair(n_sent > 1300);
      end
      req_ch.valid <= 1'b0;
      while (expected_hits.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (n_errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Result side: random back-pressure, plus one long hold while the
   // sender keeps offering so the block backs up into its input.
   initial begin
      int roll, hold;
      rsp_ch.ready   = 1'b0;
      long_hold_done = 0;
      forever begin
         @(negedge clock);
         if (!long_hold_done && n_sent > 400) begin
            long_hold_done = 1;
            rsp_ch.ready <= 1'b0;
            hold = 3000;
            while (hold > 0) begin
               @(negedge clock);
               hold--;
            end
         end
         roll = $urandom_range(0, 99);
         if (no_gaps || roll < 50) begin
            rsp_ch.ready <= 1'b1;
         end else if (roll < 93) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(0, 2)) @(negedge clock);
         end else begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(10, 60)) @(negedge clock);
         end
      end
   end

   // Compare each result transaction against the oldest prediction.
   always @(posedge clock) begin
      rsp_type e;
      rsp_type a;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         a = rsp_ch.data;
         if (expected_hits.size() == 0) begin
            $display("%0t: unexpected result collides=%0b depth=%0h", $time,
                     a.collides, a.depth);
            n_errors++;
         end else begin
            e = expected_hits.pop_front();
            if (a.collides !== e.collides) begin
               $display("%0t: collides exp %0b got %0b", $time, e.collides, a.collides);
               n_errors++;
            end
            if (a.best_normal_x !== e.best_normal_x) begin
               $display("%0t: normal x exp %0d got %0d", $time,
                        $signed(e.best_normal_x), $signed(a.best_normal_x));
               n_errors++;
            end
            if (a.best_normal_y !== e.best_normal_y) begin
               $display("%0t: normal y exp %0d got %0d", $time,
                        $signed(e.best_normal_y), $signed(a.best_normal_y));
               n_errors++;
            end
            if (a.depth !== e.depth) begin
               $display("%0t: depth exp %0h got %0h", $time, e.depth, a.depth);
               n_errors++;
            end
            if (a.overflow !== e.overflow) begin
               $display("%0t: overflow exp %0b got %0b", $time, e.overflow, a.overflow);
               n_errors++;
            end
         end
      end
   end

   // Watchdog: end the run when no transaction moves for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
